>>> src/hmab_pkg.sv
// ----------------------------------------------------------------------------
// hmab_pkg: shared types and constants of the hex memory access bridge
// Holds ASCII codes, result kinds, the command record that travels from
// the front part to the back part, and the hex conversion helpers.
// ----------------------------------------------------------------------------
package hmab_pkg;

	// ASCII characters of the command and reply frames
	localparam logic [7:0] CHAR_AT   = 8'h40;
	localparam logic [7:0] CHAR_HASH = 8'h23;
	localparam logic [7:0] CHAR_W    = 8'h57;
	localparam logic [7:0] CHAR_R    = 8'h52;

	// Receive history and frame geometry
	localparam int HIST_DEPTH = 18;
	localparam int WRITE_BACK = 18;
	localparam int READ_BACK  = 10;
	localparam int REPLY_LEN  = 19;
	localparam int STEP_W     = 5;

	// Default depth of the command queue
	localparam int QUEUE_DEPTH = 4;

	// Result kinds on the output channel
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_REPLY = 2'd2;

	// Command classes handed from front to back
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_REPLY = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] addr;
		logic [31:0] data;
	} cmd_t;

	// Value of one ASCII hex digit; anything else reads as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end
		return v;
	endfunction

	// Upper-case ASCII character of one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) begin
			c = 8'h30 + {4'd0, n};
		end else begin
			c = 8'h37 + {4'd0, n};
		end
		return c;
	endfunction

endpackage

>>> src/hmab_front.sv
// ----------------------------------------------------------------------------
// hmab_front: receive history and command classifier
// Takes every input beat, keeps the last received bytes, spots write and
// read frames on '#', tracks the pending read and issues commands.
// ----------------------------------------------------------------------------
module hmab_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              action,
	input  logic [7:0]        rx_byte,
	input  logic [31:0]       read_data,
	output logic              push,
	output hmab_pkg::cmd_t    cmd
);

	logic [7:0]  hist_q [hmab_pkg::HIST_DEPTH];
	logic        pend_q;
	logic [31:0] pend_addr_q;

	logic        is_hash;
	logic        is_wr;
	logic        is_rd;
	logic        is_rep;
	logic [31:0] low_word;
	logic [31:0] high_word;

	// Decode the two words sitting behind the current byte
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			low_word[4*i +: 4]  = hmab_pkg::hex_value(hist_q[i]);
			high_word[4*i +: 4] = hmab_pkg::hex_value(hist_q[i + 8]);
		end
	end

	// Classify the incoming beat
	assign is_hash = !action && (rx_byte == hmab_pkg::CHAR_HASH);
	assign is_wr   = is_hash && (hist_q[hmab_pkg::WRITE_BACK - 1] == hmab_pkg::CHAR_AT);
	assign is_rd   = is_hash && !is_wr
		&& (hist_q[hmab_pkg::READ_BACK - 1] == hmab_pkg::CHAR_AT);
	assign is_rep  = action && pend_q;
	assign push    = accept && (is_wr || is_rd || is_rep);

	// Build the command record
	always_comb begin
		cmd.op   = hmab_pkg::OP_REPLY;
		cmd.addr = pend_addr_q;
		cmd.data = read_data;
		if (is_wr) begin
			cmd.op   = hmab_pkg::OP_WRITE;
			cmd.addr = high_word;
			cmd.data = low_word;
		end else if (is_rd) begin
			cmd.op   = hmab_pkg::OP_READ;
			cmd.addr = low_word;
			cmd.data = 32'd0;
		end
	end

	// Shift received bytes into the history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hmab_pkg::HIST_DEPTH; i++) begin
				hist_q[i] <= 8'd0;
			end
		end else if (accept && !action) begin
			hist_q[0] <= rx_byte;
			for (int i = 1; i < hmab_pkg::HIST_DEPTH; i++) begin
				hist_q[i] <= hist_q[i - 1];
			end
		end
	end

	// Track the outstanding read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			pend_addr_q <= 32'd0;
		end else if (accept) begin
			if (is_rd) begin
				pend_q      <= 1'b1;
				pend_addr_q <= low_word;
			end else if (is_rep) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

>>> src/hmab_queue.sv
// ----------------------------------------------------------------------------
// hmab_queue: command queue between front and back
// Small register FIFO that lets the receive side run on while the back
// part is still sending the results of earlier commands.
// ----------------------------------------------------------------------------
module hmab_queue #(
	parameter int DEPTH = hmab_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hmab_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output hmab_pkg::cmd_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hmab_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command popped from an empty queue");

endmodule

>>> src/hmab_back.sv
// ----------------------------------------------------------------------------
// hmab_back: result sequencer
// Works off the head command one result per beat: a bus write followed by the
// 19-character ASCII reply, a read request, or the 19-character read reply, through an output register.
// ----------------------------------------------------------------------------
module hmab_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  hmab_pkg::cmd_t head,
	output logic           pop,
	input  logic           out_stall,
	output logic           out_valid,
	output logic [1:0]     kind,
	output logic [31:0]    bus_address,
	output logic [31:0]    bus_write_data,
	output logic [7:0]     reply_byte,
	output logic           last
);

	logic [hmab_pkg::STEP_W-1:0] step_q;
	logic                        out_valid_q;
	logic [1:0]                  kind_q;
	logic [31:0]                 addr_q;
	logic [31:0]                 wdata_q;
	logic [7:0]                  byte_q;
	logic                        last_q;

	logic                        emit;
	logic [1:0]                  nxt_kind;
	logic [31:0]                 nxt_addr;
	logic [31:0]                 nxt_wdata;
	logic [7:0]                  nxt_byte;
	logic                        nxt_last;
	logic [hmab_pkg::STEP_W-1:0] pos;
	logic [hmab_pkg::STEP_W-1:0] dig;
	logic [7:0]                  letter;
	logic [31:0]                 word;
	logic [3:0]                  nib;

	assign emit = head_valid && (!out_valid_q || !out_stall);
	assign pop  = emit && nxt_last;

	// Pick the next result of the head command
	always_comb begin
		nxt_kind  = hmab_pkg::KIND_REPLY;
		nxt_addr  = 32'd0;
		nxt_wdata = 32'd0;
		nxt_last  = 1'b0;
		pos       = step_q;
		letter    = hmab_pkg::CHAR_R;
		case (head.op)
			hmab_pkg::OP_WRITE: begin
				letter   = hmab_pkg::CHAR_W;
				pos      = step_q - 1'b1;
				nxt_last = (step_q == hmab_pkg::STEP_W'(hmab_pkg::REPLY_LEN));
				if (step_q == '0) begin
					nxt_kind  = hmab_pkg::KIND_WRITE;
					nxt_addr  = head.addr;
					nxt_wdata = head.data;
				end
			end
			hmab_pkg::OP_READ: begin
				nxt_kind = hmab_pkg::KIND_READ;
				nxt_addr = head.addr;
				nxt_last = 1'b1;
			end
			hmab_pkg::OP_REPLY: begin
				nxt_last = (step_q == hmab_pkg::STEP_W'(hmab_pkg::REPLY_LEN - 1));
			end
			default: begin
				nxt_last = 1'b1;
			end
		endcase
	end

	// Form the reply character at position pos
	always_comb begin
		if (pos < hmab_pkg::STEP_W'(10)) begin
			word = head.addr;
			dig  = pos - hmab_pkg::STEP_W'(2);
		end else begin
			word = head.data;
			dig  = pos - hmab_pkg::STEP_W'(10);
		end
		nib = word[4 * (3'd7 - dig[2:0]) +: 4];
		if (nxt_kind != hmab_pkg::KIND_REPLY) begin
			nxt_byte = 8'd0;
		end else if (pos == '0) begin
			nxt_byte = hmab_pkg::CHAR_AT;
		end else if (pos == hmab_pkg::STEP_W'(1)) begin
			nxt_byte = letter;
		end else if (pos == hmab_pkg::STEP_W'(hmab_pkg::REPLY_LEN - 1)) begin
			nxt_byte = hmab_pkg::CHAR_HASH;
		end else begin
			nxt_byte = hmab_pkg::hex_char(nib);
		end
	end

	// Advance the step counter, restart on each new command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (emit) begin
			step_q <= nxt_last ? '0 : step_q + 1'b1;
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= nxt_kind;
			addr_q  <= nxt_addr;
			wdata_q <= nxt_wdata;
			byte_q  <= nxt_byte;
			last_q  <= nxt_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign bus_address    = addr_q;
	assign bus_write_data = wdata_q;
	assign reply_byte     = byte_q;
	assign last           = last_q;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= hmab_pkg::STEP_W'(hmab_pkg::REPLY_LEN))
		else $error("step counter ran past the reply length");

	a_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == hmab_pkg::KIND_WRITE) |-> !last_q)
		else $error("bus write marked as final beat");

	a_step_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (step_q == '0))
		else $error("step counter not restarted after a command");

endmodule

>>> src/hex_memory_access_bridge_unit.sv
// ----------------------------------------------------------------------------
// hex_memory_access_bridge_unit: ASCII hex command bridge to a memory bus
// Top level: front classifier, command queue and result sequencer.
// ----------------------------------------------------------------------------
// Received bytes (action 0) and returned read words (action 1) are taken one
// beat per cycle while the command queue has room; in_stall is high only when
// all Q_DEPTH queue entries are in use. A '#' closing "@W<8 addr><8 data>#"
// gives one bus write followed by a 19-character reply (20 output beats), a
// '#' closing "@R<8 addr>#" gives one bus read request, and the read word
// returned afterwards gives the 19-character 'R' reply. The back part sends
// one output beat per cycle while out_stall is low; that sequencer sets the
// sustained rate. The last output beat of each command carries last high.
// ----------------------------------------------------------------------------
module hex_memory_access_bridge_unit #(
	parameter int Q_DEPTH = hmab_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] read_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] bus_address,
	output logic [31:0] bus_write_data,
	output logic [7:0]  reply_byte,
	output logic        last
);

	logic           accept;
	logic           push;
	hmab_pkg::cmd_t push_cmd;
	logic           full;
	logic           pop;
	logic           head_valid;
	hmab_pkg::cmd_t head;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	hmab_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.rx_byte   (rx_byte),
		.read_data (read_data),
		.push      (push),
		.cmd       (push_cmd)
	);

	hmab_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	hmab_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.kind           (kind),
		.bus_address    (bus_address),
		.bus_write_data (bus_write_data),
		.reply_byte     (reply_byte),
		.last           (last)
	);

endmodule

>>> tb/tb_hex_memory_access_bridge_unit.sv
// ----------------------------------------------------------------------------
// tb_hex_memory_access_bridge_unit: self-checking bench of the hex bridge
// Feeds ASCII command frames, stray bytes and returned read words, predicts
// the bus accesses and reply characters in step, and checks every output
// beat in order while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_hex_memory_access_bridge_unit;

	localparam int STUCK_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [31:0] wdata;
		logic [7:0]  ch;
		logic        last;
	} bridge_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        action = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic [31:0] read_data = 32'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [31:0] bus_address;
	logic [31:0] bus_write_data;
	logic [7:0]  reply_byte;
	logic        last;

	// predictor state
	logic [7:0]   rx_hist [hmab_pkg::HIST_DEPTH];
	logic         rd_pending;
	logic [31:0]  rd_pending_addr;
	bridge_beat_t bridge_output_q [$];

	int send_idle_pct = 36;
	int recv_idle_pct = 69;
	int items_sent = 0;
	int mismatch_count = 0;
	int stuck_cycles = 0;

	hex_memory_access_bridge_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.rx_byte(rx_byte),
		.read_data(read_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.bus_address(bus_address),
		.bus_write_data(bus_write_data),
		.reply_byte(reply_byte),
		.last(last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [3:0] digit_val(logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
		end else if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 10);
		end else if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 10);
		end
		return v;
	endfunction

	function automatic logic [7:0] nibble_char(logic [3:0] n);
		logic [7:0] c;
		c = (n < 4'd10) ? 8'("0" + n) : 8'("A" + n - 10);
		return c;
	endfunction

	function automatic void push_beat(logic [1:0] k, logic [31:0] a, logic [31:0] d,
			logic [7:0] c, logic l);
		bridge_beat_t b;
		b.kind = k;
		b.addr = a;
		b.wdata = d;
		b.ch = c;
		b.last = l;
		bridge_output_q.push_back(b);
	endfunction

	// Queue the 19-character reply frame
	function automatic void queue_reply(logic [7:0] letter, logic [31:0] a, logic [31:0] d);
		push_beat(hmab_pkg::KIND_REPLY, 32'h0, 32'h0, hmab_pkg::CHAR_AT, 1'b0);
		push_beat(hmab_pkg::KIND_REPLY, 32'h0, 32'h0, letter, 1'b0);
		for (int i = 0; i < 8; i++) begin
			push_beat(hmab_pkg::KIND_REPLY, 32'h0, 32'h0,
				nibble_char(a[31 - 4 * i -: 4]), 1'b0);
		end
		for (int i = 0; i < 8; i++) begin
			push_beat(hmab_pkg::KIND_REPLY, 32'h0, 32'h0,
				nibble_char(d[31 - 4 * i -: 4]), 1'b0);
		end
		push_beat(hmab_pkg::KIND_REPLY, 32'h0, 32'h0, hmab_pkg::CHAR_HASH, 1'b1);
	endfunction

	function automatic void predict_bridge_output(logic act, logic [7:0] c, logic [31:0] rd);
		logic [31:0] a;
		logic [31:0] d;
		a = 32'h0;
		d = 32'h0;
		if (act) begin
			if (rd_pending) begin
				queue_reply(hmab_pkg::CHAR_R, rd_pending_addr, rd);
				rd_pending = 1'b0;
			end
			return;
		end
		if (c == hmab_pkg::CHAR_HASH) begin
			if (rx_hist[hmab_pkg::WRITE_BACK - 1] == hmab_pkg::CHAR_AT) begin
				// write wins when both marker positions hold '@'
				for (int i = 0; i < 8; i++) begin
					d |= 32'(digit_val(rx_hist[i])) << (4 * i);
					a |= 32'(digit_val(rx_hist[8 + i])) << (4 * i);
				end
				push_beat(hmab_pkg::KIND_WRITE, a, d, 8'h00, 1'b0);
				queue_reply(hmab_pkg::CHAR_W, a, d);
			end else if (rx_hist[hmab_pkg::READ_BACK - 1] == hmab_pkg::CHAR_AT) begin
				for (int i = 0; i < 8; i++) begin
					a |= 32'(digit_val(rx_hist[i])) << (4 * i);
				end
				push_beat(hmab_pkg::KIND_READ, a, 32'h0, 8'h00, 1'b1);
				rd_pending = 1'b1;
				rd_pending_addr = a;
			end
		end
		// shift the byte into the history
		for (int i = hmab_pkg::HIST_DEPTH - 1; i > 0; i--) begin
			rx_hist[i] = rx_hist[i - 1];
		end
		rx_hist[0] = c;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic send_rx_beat(logic act, logic [7:0] c, logic [31:0] rd);
		// idle the sender for a random while
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		rx_byte <= act ? 8'($urandom_range(0, 255)) : c;
		read_data <= act ? rd : 32'($urandom);
		do begin
			@(posedge clk);
		end while (in_stall);
		predict_bridge_output(act, c, rd);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_rx_beat(1'b0, s[i], 32'h0);
		end
	endtask

	function automatic logic [7:0] rand_digit();
		logic [3:0] n;
		logic [7:0] c;
		n = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: c = nibble_char(n);
			6, 7, 8: c = (n < 4'd10) ? nibble_char(n) : nibble_char(n) + 8'h20;
			default: c = 8'($urandom_range(0, 255));
		endcase
		return c;
	endfunction

	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		case ($urandom_range(0, 5))
			0: w = 32'h0;
			1: w = 32'hFFFF_FFFF;
			default: w = 32'($urandom);
		endcase
		return w;
	endfunction

	// Send '@', a letter, n digits and optionally the closing '#'
	task automatic send_frame(logic [7:0] letter, int n_digits, bit closed);
		send_rx_beat(1'b0, hmab_pkg::CHAR_AT, 32'h0);
		send_rx_beat(1'b0, letter, 32'h0);
		for (int i = 0; i < n_digits; i++) begin
			send_rx_beat(1'b0, rand_digit(), 32'h0);
		end
		if (closed) begin
			send_rx_beat(1'b0, hmab_pkg::CHAR_HASH, 32'h0);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Unchecked letter, '@' in both marker slots, lower case and non-hex digits
	task automatic test_write_frame();
		send_text("@xFFFFFF@F0a9fGz7B#");
	endtask

	// Stray read word, then a read of address zero answered with all ones
	task automatic test_read_frame();
		send_rx_beat(1'b1, 8'h00, 32'hFFFF_FFFF);
		send_text("@R00000000#");
		send_rx_beat(1'b1, 8'h00, 32'hFFFF_FFFF);
	endtask

	task automatic test_random_traffic(int n_items);
		int stop;
		int r;
		stop = items_sent + n_items;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				send_frame(($urandom_range(0, 9) != 0) ? hmab_pkg::CHAR_W
					: 8'($urandom_range(0, 255)), 16, 1'b1);
			end else if (r < 70) begin
				send_frame(($urandom_range(0, 9) != 0) ? hmab_pkg::CHAR_R
					: 8'($urandom_range(0, 255)), 8, 1'b1);
				// leave some reads open so later commands find one pending
				if ($urandom_range(0, 9) < 7) begin
					send_rx_beat(1'b1, 8'h00, rand_word());
				end
			end else if (r < 80) begin
				send_rx_beat(1'b1, 8'h00, rand_word());
			end else if (r < 90) begin
				send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 17), 1'b1);
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_rx_beat(1'b0, 8'($urandom_range(0, 255)), 32'h0);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: random stall, checking, watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		bridge_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bridge_output_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: unexpected beat kind=%0d addr=%h data=%h char=%h last=%b",
						$time, kind, bus_address, bus_write_data, reply_byte, last);
				end
			end else begin
				want = bridge_output_q.pop_front();
				if (kind !== want.kind || bus_address !== want.addr ||
						bus_write_data !== want.wdata || reply_byte !== want.ch ||
						last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: expected kind=%0d addr=%h data=%h char=%h last=%b",
							$time, want.kind, want.addr, want.wdata, want.ch, want.last);
						$display("%0t: actual   kind=%0d addr=%h data=%h char=%h last=%b",
							$time, kind, bus_address, bus_write_data, reply_byte, last);
					end
				end
			end
		end
	end

	// Abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb_hex_memory_access_bridge_unit: done, errors");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		for (int i = 0; i < hmab_pkg::HIST_DEPTH; i++) begin
			rx_hist[i] = 8'h00;
		end
		rd_pending = 1'b0;
		rd_pending_addr = 32'h0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_write_frame();
		test_read_frame();
		test_random_traffic(35);

		send_idle_pct = 69;
		recv_idle_pct = 36;
		test_random_traffic(35);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(35);
		in_valid <= 1'b0;

		// drain outstanding results, then watch for stray beats
		while (bridge_output_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatch_count += bridge_output_q.size();
		if (mismatch_count == 0) begin
			$display("tb_hex_memory_access_bridge_unit: done, clean");
		end else begin
			$display("tb_hex_memory_access_bridge_unit: done, errors");
		end
		$finish;
	end

endmodule

>>> hex_memory_access_bridge_unit.f
src/hmab_pkg.sv
src/hmab_front.sv
src/hmab_queue.sv
src/hmab_back.sv
src/hex_memory_access_bridge_unit.sv
tb/tb_hex_memory_access_bridge_unit.sv
